/* rtl/pplsnd_pkg.sv */
// Package for the parallel port loader sender: payload structs, mode and
// phase codes, register indexes and the front-to-back command struct.
// No dependencies.
`timescale 1ns / 1ps

package pplsnd_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOAD_ORIGIN   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSFER_SIZE = 8'd1;

   localparam logic [15:0] LOAD_ORIGIN_RESET   = 16'h0100;
   localparam logic [15:0] TRANSFER_SIZE_RESET = 16'h0000;

   // status port bits: busy is the inverted bit 7, ack is bit 6
   localparam int STATUS_BUSY_N_BIT = 7;
   localparam int STATUS_ACK_BIT    = 6;

   // header is origin high, origin low, size high, size low
   localparam logic [2:0] HEADER_LEN = 3'd4;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_OFFER  = 2'd1,
      MODE_START  = 2'd2,
      MODE_FINISH = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'b001,
      PH_WAIT_READY = 3'b010,
      PH_WAIT_DONE  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic [7:0] status_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] data_lines;
      logic       strobe_line;
      logic       init_line;
      logic       byte_taken;
      logic       byte_finished;
      logic       ready_for_byte;
      logic       target_already_ready;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      mode_type   mode;
      logic [7:0] data_byte;
      logic       ready_seen;   // busy true and ack low
      logic       done_seen;    // busy false and ack high
   } cmd_type;

endpackage

/* rtl/parallel_port_loader_sender.sv */
// Top level of the parallel port loader sender: front classifier, command
// queue and back handshake engine. Depends on pplsnd_pkg, pplsnd_front,
// pplsnd_queue and pplsnd_back.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  pplsnd_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready  pplsnd_pkg::rsp_type
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One request per cycle while the queue has room. A command passes through
// the queue to the back engine, which registers the response in its output
// register. Reset is synchronous; it clears link state and the queue and
// loads the config registers with their reset values. A stalled rsp channel
// fills the queue (QUEUE_DEPTH entries) before req_ready drops.
`timescale 1ns / 1ps

module parallel_port_loader_sender #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pplsnd_pkg::req_type                req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pplsnd_pkg::rsp_type                rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pplsnd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                        csr_data
);
   import pplsnd_pkg::*;

   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    back_valid;
   logic    back_ready;

   pplsnd_front u_front (
      .req (req_payload),
      .cmd (front_cmd)
   );

   pplsnd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   pplsnd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd_valid   (back_valid),
      .cmd_ready   (back_ready),
      .cmd         (back_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/pplsnd_front.sv */
// Front part of the parallel port loader sender: decodes the mode and the
// raw status sample of each request into a command. Depends on pplsnd_pkg.
`timescale 1ns / 1ps

module pplsnd_front (
   input  pplsnd_pkg::req_type req,
   output pplsnd_pkg::cmd_type cmd
);
   import pplsnd_pkg::*;

   logic busy;
   logic ack;

   // busy is active low on the port
   assign busy = ~req.status_byte[STATUS_BUSY_N_BIT];
   assign ack  = req.status_byte[STATUS_ACK_BIT];

   // classify the sample against the two handshake conditions
   always_comb begin
      cmd.mode       = mode_type'(req.mode);
      cmd.data_byte  = req.data_byte;
      cmd.ready_seen = busy & ~ack;
      cmd.done_seen  = ~busy & ack;
   end

endmodule

/* rtl/pplsnd_queue.sv */
// Short command queue between front and back of the parallel port loader
// sender. Register based, DEPTH entries. Depends on pplsnd_pkg.
`timescale 1ns / 1ps

module pplsnd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  pplsnd_pkg::cmd_type push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output pplsnd_pkg::cmd_type pop_cmd
);
   import pplsnd_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/pplsnd_back.sv */
// Back part of the parallel port loader sender: holds the link state and
// configuration, runs the strobe/busy/ack handshake one command per cycle
// unless rsp stalls, and keeps the response output register. Depends on pplsnd_pkg.
`timescale 1ns / 1ps

module pplsnd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pplsnd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                       csr_data,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  pplsnd_pkg::cmd_type               cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pplsnd_pkg::rsp_type               rsp_payload
);
   import pplsnd_pkg::*;

   logic [15:0] origin_ff;
   logic [15:0] size_ff;
   phase_type   phase_ff, phase_in;
   logic [2:0]  header_left_ff, header_left_in;
   logic [7:0]  pending_ff, pending_in;
   logic [7:0]  data_ff, data_in;
   logic        strobe_ff, strobe_in;
   logic        init_ff, init_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        pop;
   logic        was_ready;
   logic        idle_now;
   logic        taken;
   logic        finished;
   logic        already;

   function automatic logic [7:0] header_byte(input logic [2:0] left,
                                              input logic [15:0] origin,
                                              input logic [15:0] size);
      logic [7:0] b;
      case (left)
         3'd4:    b = origin[15:8];
         3'd3:    b = origin[7:0];
         3'd2:    b = size[15:8];
         default: b = size[7:0];
      endcase
      return b;
   endfunction

   assign csr_ready   = 1'b1;
   assign pop         = cmd_valid & (~rsp_valid_ff | rsp_ready);
   assign cmd_ready   = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign was_ready   = (phase_ff == PH_IDLE) && (header_left_ff == '0);

   // start mode resets the link; otherwise handshake step, finish, then byte launch
   always_comb begin
      phase_in       = phase_ff;
      header_left_in = header_left_ff;
      pending_in     = pending_ff;
      data_in        = data_ff;
      strobe_in      = strobe_ff;
      init_in        = init_ff;
      taken          = 1'b0;
      finished       = 1'b0;
      already        = 1'b0;
      idle_now       = 1'b1;

      if (cmd.mode == MODE_START) begin
         strobe_in      = 1'b0;
         init_in        = 1'b0;
         already        = cmd.ready_seen;
         header_left_in = HEADER_LEN;
         phase_in       = PH_IDLE;
      end else begin
         case (phase_ff)
            PH_WAIT_READY: begin
               if (cmd.ready_seen) begin
                  data_in   = pending_ff;
                  strobe_in = 1'b0;
                  phase_in  = PH_WAIT_DONE;
               end
            end
            PH_WAIT_DONE: begin
               if (cmd.done_seen) begin
                  phase_in = PH_IDLE;
                  finished = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (cmd.mode == MODE_FINISH) begin
            init_in = 1'b1;
         end
         idle_now = (phase_in != PH_WAIT_READY) && (phase_in != PH_WAIT_DONE);
         if (idle_now && (header_left_ff != '0)) begin
            pending_in     = header_byte(header_left_ff, origin_ff, size_ff);
            strobe_in      = 1'b1;
            phase_in       = PH_WAIT_READY;
            header_left_in = header_left_ff - 1'b1;
         end else if ((cmd.mode == MODE_OFFER) && was_ready && idle_now) begin
            pending_in = cmd.data_byte;
            strobe_in  = 1'b1;
            phase_in   = PH_WAIT_READY;
            taken      = 1'b1;
         end
      end

      rsp_in.data_lines           = data_in;
      rsp_in.strobe_line          = strobe_in;
      rsp_in.init_line            = init_in;
      rsp_in.byte_taken           = taken;
      rsp_in.byte_finished        = finished;
      rsp_in.ready_for_byte       = (phase_in == PH_IDLE) && (header_left_in == '0);
      rsp_in.target_already_ready = already;

      rsp_valid_in = pop | (rsp_valid_ff & ~rsp_ready);
   end

   // link state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         header_left_ff <= '0;
         pending_ff     <= '0;
         data_ff        <= '0;
         strobe_ff      <= 1'b0;
         init_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff       <= phase_in;
            header_left_ff <= header_left_in;
            pending_ff     <= pending_in;
            data_ff        <= data_in;
            strobe_ff      <= strobe_in;
            init_ff        <= init_in;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   // configuration registers; other indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= LOAD_ORIGIN_RESET;
         size_ff   <= TRANSFER_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOAD_ORIGIN:   origin_ff <= csr_data;
            CSR_TRANSFER_SIZE: size_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

/* rtl/pplsnd_checker.sv */
// Port-level checker for the parallel port loader sender and the bind that
// attaches it to the top level. Depends on pplsnd_pkg.
`timescale 1ns / 1ps

module pplsnd_checker #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input pplsnd_pkg::rsp_type rsp_payload
);
   import pplsnd_pkg::*;

   localparam int OUT_W = $clog2(QUEUE_DEPTH + 2) + 1;
   localparam logic [OUT_W-1:0] MAX_OUT = OUT_W'(QUEUE_DEPTH + 1);

   logic [OUT_W-1:0] outstanding_ff;
   logic             req_fire;
   logic             rsp_fire;

   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;

   // requests accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         outstanding_ff <= outstanding_ff + 1'b1;
      end else if (!req_fire && rsp_fire) begin
         outstanding_ff <= outstanding_ff - 1'b1;
      end
   end

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // no response shows right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every response answers an earlier request, queue plus output bound
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("response without request");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= MAX_OUT)
      else $error("more requests in flight than storage");

   // a start response that saw the target ready clears the lines and takes no byte
   a_start_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.target_already_ready |->
         !rsp_payload.strobe_line && !rsp_payload.init_line &&
         !rsp_payload.byte_taken && !rsp_payload.byte_finished &&
         !rsp_payload.ready_for_byte)
      else $error("start response with wrong line state");

endmodule

bind parallel_port_loader_sender pplsnd_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pplsnd_checker (.*);
